/* design/lfu_pkg.sv */
// ----------------------------------------------------------------------------
// lfu_pkg
// Shared constants and controller/datapath interface types for the
// least-frequently-used page replacement block.
// ----------------------------------------------------------------------------
package lfu_pkg;

   // default sizes
   localparam int SLOTS_DEFAULT     = 16;
   localparam int PAGE_BITS_DEFAULT = 16;

   // fixed field widths
   localparam int COUNT_W      = 16;
   localparam int FAULT_W      = 16;
   localparam int SLOT_INDEX_W = 4;
   localparam int CFG_W        = 5;

   // saturation limits and reset value of the slot count register
   localparam logic [COUNT_W-1:0] COUNT_MAX          = '1;
   localparam logic [FAULT_W-1:0] FAULT_MAX          = '1;
   localparam logic [CFG_W-1:0]   SLOTS_IN_USE_RESET = 5'd16;

   // controller to datapath commands
   typedef struct packed {
      logic start;        // latch request, clear lookup results
      logic rd;           // read table entry at the walk pointer
      logic sweep_start;  // restart the walk over all slots for rank fixup
      logic commit;       // write the chosen slot and load the result
   } lfu_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic rd_done;      // walk pointer reached its limit
      logic rd_pend;      // a read is still in flight
      logic need_sweep;   // fault with no empty slot
      logic out_free;     // result register can take a new result
   } lfu_stat_type;

endpackage

/* design/lfu_ram.sv */
// ----------------------------------------------------------------------------
// lfu_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module lfu_ram #(
   parameter int WIDTH = lfu_pkg::COUNT_W,
   parameter int DEPTH = lfu_pkg::SLOTS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/lfu_datapath.sv */
// ----------------------------------------------------------------------------
// lfu_datapath
// Slot table, lookup and victim tracking, rank fixup, fault counter and
// result register.
// ----------------------------------------------------------------------------
module lfu_datapath #(
   parameter int SLOTS     = lfu_pkg::SLOTS_DEFAULT,
   parameter int PAGE_BITS = lfu_pkg::PAGE_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  lfu_pkg::lfu_cmd_type              cmd,
   output lfu_pkg::lfu_stat_type             stat,
   input  logic [PAGE_BITS-1:0]              req_page,
   input  logic                              req_end_of_run,
   input  logic                              csr_we,
   input  logic [lfu_pkg::CFG_W-1:0]         csr_slots_in_use,
   input  logic                              rsp_stall,
   output logic                              rsp_valid,
   output logic                              rsp_hit,
   output logic [lfu_pkg::SLOT_INDEX_W-1:0]  rsp_slot_index,
   output logic [lfu_pkg::FAULT_W-1:0]       rsp_fault_count
);

   localparam int IW = $clog2(SLOTS);
   localparam int CW = $clog2(SLOTS + 1);
   localparam int RW = IW;

   typedef struct packed {
      logic [PAGE_BITS-1:0]        tag;
      logic [lfu_pkg::COUNT_W-1:0] count;
      logic [RW-1:0]               rank;
   } entry_type;

   localparam int EW = $bits(entry_type);

   // configuration and request
   logic [lfu_pkg::CFG_W-1:0]        slots_in_use_ff, slots_in_use_in;
   logic [PAGE_BITS-1:0]             tag_ff, tag_in;
   logic                             eor_ff, eor_in;
   logic [CW-1:0]                    n_ff, n_in;
   logic [CW-1:0]                    active_n;

   // table state kept in flops
   logic [SLOTS-1:0]                 valid_ff, valid_in;
   logic [CW-1:0]                    valid_cnt_ff, valid_cnt_in;
   logic [lfu_pkg::FAULT_W-1:0]      faults_ff, faults_in;

   // walk pointer and read pipeline
   logic [CW-1:0]                    rd_cnt_ff, rd_cnt_in;
   logic                             rd_pend_ff, rd_pend_in;
   logic [IW-1:0]                    rd_idx_ff, rd_idx_in;
   logic                             sweep_ff, sweep_in;
   logic [CW-1:0]                    limit;

   // lookup results
   logic                             hit_ff, hit_in;
   logic [IW-1:0]                    hit_idx_ff, hit_idx_in;
   logic [lfu_pkg::COUNT_W-1:0]      hit_cnt_ff, hit_cnt_in;
   logic [RW-1:0]                    hit_rank_ff, hit_rank_in;
   logic                             emp_ff, emp_in;
   logic [IW-1:0]                    emp_idx_ff, emp_idx_in;
   logic                             vic_ok_ff, vic_ok_in;
   logic [IW-1:0]                    vic_idx_ff, vic_idx_in;
   logic [lfu_pkg::COUNT_W-1:0]      vic_cnt_ff, vic_cnt_in;
   logic [RW-1:0]                    vic_rank_ff, vic_rank_in;

   // result register
   logic                             rsp_valid_ff, rsp_valid_in;
   logic                             rsp_hit_ff, rsp_hit_in;
   logic [lfu_pkg::SLOT_INDEX_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic [lfu_pkg::FAULT_W-1:0]      rsp_faults_ff, rsp_faults_in;

   // memory side
   logic [EW-1:0]                    ram_rd_data;
   logic [EW-1:0]                    ram_wr_data;
   logic [IW-1:0]                    ram_wr_addr;
   logic                             ram_wr_en;
   entry_type                        rd_entry;
   entry_type                        commit_entry;
   entry_type                        sweep_entry;
   logic                             ent_valid;
   logic                             better;
   logic                             sweep_wr;
   logic [IW-1:0]                    slot_sel;
   logic [lfu_pkg::COUNT_W-1:0]      cnt_inc;
   logic [RW-1:0]                    new_rank;
   logic [lfu_pkg::FAULT_W-1:0]      faults_inc;

   // tag, use count and insertion rank per slot
   lfu_ram #(
      .WIDTH (EW),
      .DEPTH (SLOTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (cmd.rd),
      .rd_addr (rd_cnt_ff[IW-1:0]),
      .rd_data (ram_rd_data)
   );

   // clamp slot count to 1 .. SLOTS
   always_comb begin
      if (slots_in_use_ff == '0) begin
         active_n = CW'(1);
      end else if (32'(slots_in_use_ff) > 32'(SLOTS)) begin
         active_n = CW'(SLOTS);
      end else begin
         active_n = CW'(slots_in_use_ff);
      end
   end

   // walk limit: active slots for lookup, all slots for rank fixup
   assign limit     = sweep_ff ? CW'(SLOTS) : n_ff;
   assign rd_entry  = entry_type'(ram_rd_data);
   assign ent_valid = valid_ff[rd_idx_ff];

   // victim order: lower count, then older insertion, then lower index
   assign better = !vic_ok_ff || (rd_entry.count < vic_cnt_ff) ||
                   ((rd_entry.count == vic_cnt_ff) && (rd_entry.rank < vic_rank_ff));

   // rank fixup writes back entries newer than the victim
   assign sweep_wr = rd_pend_ff && sweep_ff && ent_valid && (rd_entry.rank > vic_rank_ff);

   always_comb begin
      sweep_entry      = rd_entry;
      sweep_entry.rank = rd_entry.rank - RW'(1);
   end

   // chosen slot and its new contents
   always_comb begin
      if (hit_ff) begin
         slot_sel = hit_idx_ff;
      end else if (emp_ff) begin
         slot_sel = emp_idx_ff;
      end else begin
         slot_sel = vic_idx_ff;
      end
   end

   assign cnt_inc    = (hit_cnt_ff == lfu_pkg::COUNT_MAX) ? hit_cnt_ff
                                                          : hit_cnt_ff + lfu_pkg::COUNT_W'(1);
   assign new_rank   = emp_ff ? RW'(valid_cnt_ff) : RW'(valid_cnt_ff - CW'(1));
   assign faults_inc = (!hit_ff && (faults_ff != lfu_pkg::FAULT_MAX))
                       ? faults_ff + lfu_pkg::FAULT_W'(1) : faults_ff;

   always_comb begin
      commit_entry.tag   = tag_ff;
      commit_entry.count = hit_ff ? cnt_inc : lfu_pkg::COUNT_W'(1);
      commit_entry.rank  = hit_ff ? hit_rank_ff : new_rank;
   end

   // table write mux
   assign ram_wr_en   = sweep_wr || cmd.commit;
   assign ram_wr_addr = cmd.commit ? slot_sel : rd_idx_ff;
   assign ram_wr_data = cmd.commit ? EW'(commit_entry) : EW'(sweep_entry);

   // request capture and walk pointer
   always_comb begin
      slots_in_use_in = csr_we ? csr_slots_in_use : slots_in_use_ff;
      tag_in          = cmd.start ? req_page : tag_ff;
      eor_in          = cmd.start ? req_end_of_run : eor_ff;
      n_in            = cmd.start ? active_n : n_ff;
      rd_pend_in      = cmd.rd;
      rd_idx_in       = rd_cnt_ff[IW-1:0];
      rd_cnt_in       = rd_cnt_ff;
      sweep_in        = sweep_ff;
      if (cmd.start || cmd.sweep_start) begin
         rd_cnt_in = '0;
         sweep_in  = cmd.sweep_start;
      end else if (cmd.rd) begin
         rd_cnt_in = rd_cnt_ff + CW'(1);
      end
   end

   // lookup: first match, first empty slot, best victim
   always_comb begin
      hit_in      = hit_ff;
      hit_idx_in  = hit_idx_ff;
      hit_cnt_in  = hit_cnt_ff;
      hit_rank_in = hit_rank_ff;
      emp_in      = emp_ff;
      emp_idx_in  = emp_idx_ff;
      vic_ok_in   = vic_ok_ff;
      vic_idx_in  = vic_idx_ff;
      vic_cnt_in  = vic_cnt_ff;
      vic_rank_in = vic_rank_ff;
      if (cmd.start) begin
         hit_in    = 1'b0;
         emp_in    = 1'b0;
         vic_ok_in = 1'b0;
      end else if (rd_pend_ff && !sweep_ff) begin
         if (!hit_ff && ent_valid && (rd_entry.tag == tag_ff)) begin
            hit_in      = 1'b1;
            hit_idx_in  = rd_idx_ff;
            hit_cnt_in  = rd_entry.count;
            hit_rank_in = rd_entry.rank;
         end
         if (!emp_ff && !ent_valid) begin
            emp_in     = 1'b1;
            emp_idx_in = rd_idx_ff;
         end
         if (better) begin
            vic_ok_in   = 1'b1;
            vic_idx_in  = rd_idx_ff;
            vic_cnt_in  = rd_entry.count;
            vic_rank_in = rd_entry.rank;
         end
      end
   end

   // table bookkeeping and result register
   always_comb begin
      valid_in      = valid_ff;
      valid_cnt_in  = valid_cnt_ff;
      faults_in     = faults_ff;
      rsp_hit_in    = rsp_hit_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_faults_in = rsp_faults_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      if (cmd.commit) begin
         rsp_valid_in  = 1'b1;
         rsp_hit_in    = hit_ff;
         rsp_slot_in   = lfu_pkg::SLOT_INDEX_W'(slot_sel);
         rsp_faults_in = faults_inc;
         if (eor_ff) begin
            // end of run clears the table after reporting
            valid_in     = '0;
            valid_cnt_in = '0;
            faults_in    = '0;
         end else begin
            valid_in[slot_sel] = 1'b1;
            faults_in          = faults_inc;
            if (!hit_ff && emp_ff) begin
               valid_cnt_in = valid_cnt_ff + CW'(1);
            end
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         slots_in_use_ff <= lfu_pkg::SLOTS_IN_USE_RESET;
         valid_ff        <= '0;
         valid_cnt_ff    <= '0;
         faults_ff       <= '0;
         rd_pend_ff      <= 1'b0;
         rd_cnt_ff       <= '0;
         sweep_ff        <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         slots_in_use_ff <= slots_in_use_in;
         valid_ff        <= valid_in;
         valid_cnt_ff    <= valid_cnt_in;
         faults_ff       <= faults_in;
         rd_pend_ff      <= rd_pend_in;
         rd_cnt_ff       <= rd_cnt_in;
         sweep_ff        <= sweep_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      tag_ff        <= tag_in;
      eor_ff        <= eor_in;
      n_ff          <= n_in;
      rd_idx_ff     <= rd_idx_in;
      hit_ff        <= hit_in;
      hit_idx_ff    <= hit_idx_in;
      hit_cnt_ff    <= hit_cnt_in;
      hit_rank_ff   <= hit_rank_in;
      emp_ff        <= emp_in;
      emp_idx_ff    <= emp_idx_in;
      vic_ok_ff     <= vic_ok_in;
      vic_idx_ff    <= vic_idx_in;
      vic_cnt_ff    <= vic_cnt_in;
      vic_rank_ff   <= vic_rank_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_faults_ff <= rsp_faults_in;
   end

   // status to controller
   assign stat.rd_done    = (rd_cnt_ff == limit);
   assign stat.rd_pend    = rd_pend_ff;
   assign stat.need_sweep = !hit_ff && !emp_ff;
   assign stat.out_free   = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_slot_index  = rsp_slot_ff;
   assign rsp_fault_count = rsp_faults_ff;

endmodule

/* design/lfu_ctrl.sv */
// ----------------------------------------------------------------------------
// lfu_ctrl
// Sequencer: accept a reference, walk the active slots, walk all slots for
// rank fixup when a full table faults, then commit the update and result.
// ----------------------------------------------------------------------------
module lfu_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  lfu_pkg::lfu_stat_type stat,
   output lfu_pkg::lfu_cmd_type  cmd,
   output logic                  idle
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SCAN   = 2'd1;
   localparam logic [1:0] S_SWEEP  = 2'd2;
   localparam logic [1:0] S_COMMIT = 2'd3;

   logic [1:0] state_ff, state_in;

   // next state and commands
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = S_SCAN;
            end
         end
         S_SCAN: begin
            if (!stat.rd_done) begin
               cmd.rd = 1'b1;
            end else if (!stat.rd_pend) begin
               if (stat.need_sweep) begin
                  cmd.sweep_start = 1'b1;
                  state_in        = S_SWEEP;
               end else begin
                  state_in = S_COMMIT;
               end
            end
         end
         S_SWEEP: begin
            if (!stat.rd_done) begin
               cmd.rd = 1'b1;
            end else if (!stat.rd_pend) begin
               state_in = S_COMMIT;
            end
         end
         S_COMMIT: begin
            if (stat.out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign idle = (state_ff == S_IDLE);

endmodule

/* design/lfu_page_replacement.sv */
// ----------------------------------------------------------------------------
// lfu_page_replacement
// Least-frequently-used page replacement with oldest-first tie-break.
// ----------------------------------------------------------------------------
// One reference is handled at a time. After a transfer on the request channel
// the block reads the slot table one entry per cycle through its single read
// port, walking the first n entries, n being the active slot count
// (slots_in_use, clamped to 1..SLOTS). A fault on a table whose active slots
// are all filled adds a second walk over all SLOTS entries to renumber the
// insertion ranks. The result goes to an output register, so the next
// reference is taken while a result still waits on a stalled response
// channel; a commit waits only if a previous result is still held there.
// The slot count register is written through the csr channel while no
// reference is in flight.
// ----------------------------------------------------------------------------
module lfu_page_replacement #(
   parameter int SLOTS     = lfu_pkg::SLOTS_DEFAULT,
   parameter int PAGE_BITS = lfu_pkg::PAGE_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [PAGE_BITS-1:0]              req_page,
   input  logic                              req_end_of_run,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_hit,
   output logic [lfu_pkg::SLOT_INDEX_W-1:0]  rsp_slot_index,
   output logic [lfu_pkg::FAULT_W-1:0]       rsp_fault_count,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [lfu_pkg::CFG_W-1:0]         csr_slots_in_use
);

   lfu_pkg::lfu_cmd_type  cmd;
   lfu_pkg::lfu_stat_type stat;
   logic                  idle;
   logic                  csr_we;

   // handshakes
   assign req_stall = !idle;
   assign csr_ready = idle;
   assign csr_we    = csr_valid && csr_ready;

   lfu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .stat      (stat),
      .cmd       (cmd),
      .idle      (idle)
   );

   lfu_datapath #(
      .SLOTS     (SLOTS),
      .PAGE_BITS (PAGE_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_page         (req_page),
      .req_end_of_run   (req_end_of_run),
      .csr_we           (csr_we),
      .csr_slots_in_use (csr_slots_in_use),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_hit          (rsp_hit),
      .rsp_slot_index   (rsp_slot_index),
      .rsp_fault_count  (rsp_fault_count)
   );

   // a fault result always carries a nonzero fault total
   a_fault_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_hit || (rsp_fault_count != '0)))
      else $error("fault reported with zero fault count");

   // one reference at a time: busy right after a request transfer
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken while a reference is in flight");

   // a new result only comes out of the commit step
   a_result_from_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared without a reference in flight");

endmodule

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for lfu_page_replacement. A scoreboard keeps its own
// copy of the slot table and predicts hit, slot and fault total for every
// reference taken on the request channel. Responses are compared in order.
// Stimulus is a directed opening, then random phases at several slot counts
// with random gaps on both channels, and a run of hits on one slot that
// lifts its use count well above the others.
// ----------------------------------------------------------------------------

localparam int TABLE_SLOTS = lfu_pkg::SLOTS_DEFAULT;

typedef struct packed {
   logic                              hit;
   logic [lfu_pkg::SLOT_INDEX_W-1:0]  slot_index;
   logic [lfu_pkg::FAULT_W-1:0]       fault_count;
} lfu_outcome_type;

// slot table predictor plus in-order store of expected responses
class lfu_scoreboard;
   logic [15:0]               page_tag [TABLE_SLOTS];
   bit                        resident [TABLE_SLOTS];
   int unsigned               use_count [TABLE_SLOTS];
   int unsigned               age_rank [TABLE_SLOTS];
   int unsigned               fault_total;
   logic [lfu_pkg::CFG_W-1:0] slot_setting;
   lfu_outcome_type           outcome_q [$];
   int unsigned               mismatches;
   int unsigned               checked;
   int unsigned               references;
   int unsigned               hits;
   int unsigned               clears;
   int unsigned               peak_use;

   function new();
      slot_setting = lfu_pkg::SLOTS_IN_USE_RESET;
      mismatches   = 0;
      checked      = 0;
      references   = 0;
      hits         = 0;
      clears       = 0;
      peak_use     = 0;
      clear_table();
   endfunction

   function void clear_table();
      foreach (resident[i]) begin
         resident[i]  = 1'b0;
         use_count[i] = 0;
         age_rank[i]  = 0;
         page_tag[i]  = '0;
      end
      fault_total = 0;
   endfunction

   function void set_slot_count(logic [lfu_pkg::CFG_W-1:0] value);
      slot_setting = value;
   endfunction

   function int unsigned pending();
      return outcome_q.size();
   endfunction

   // predict the response to one accepted reference
   function void note_reference(logic [15:0] page, logic last);
      int unsigned     n;
      int unsigned     victim;
      int unsigned     filled;
      bit              found;
      bit              empty_seen;
      lfu_outcome_type outcome;
      n          = (slot_setting == 0) ? 1 :
                   (slot_setting > TABLE_SLOTS) ? TABLE_SLOTS : slot_setting;
      victim     = 0;
      filled     = 0;
      found      = 1'b0;
      empty_seen = 1'b0;
      references++;

      // lookup among active slots only
      for (int i = 0; i < n; i++) begin
         if (!found && resident[i] && page_tag[i] == page) begin
            found  = 1'b1;
            victim = i;
         end
      end

      if (found) begin
         hits++;
         if (use_count[victim] < lfu_pkg::COUNT_MAX) use_count[victim]++;
      end else begin
         // ranks count every filled slot, active or not
         foreach (resident[i]) if (resident[i]) filled++;
         for (int i = 0; i < n; i++) begin
            if (!empty_seen && !resident[i]) begin
               empty_seen = 1'b1;
               victim     = i;
            end
         end
         if (empty_seen) begin
            age_rank[victim] = filled;
         end else begin
            // least used, then oldest, then lowest index
            victim = 0;
            for (int i = 1; i < n; i++) begin
               if (use_count[i] < use_count[victim] ||
                   (use_count[i] == use_count[victim] && age_rank[i] < age_rank[victim]))
                  victim = i;
            end
            foreach (resident[i]) begin
               if (resident[i] && age_rank[i] > age_rank[victim]) age_rank[i]--;
            end
            age_rank[victim] = filled - 1;
         end
         page_tag[victim]  = page;
         resident[victim]  = 1'b1;
         use_count[victim] = 1;
         if (fault_total < lfu_pkg::FAULT_MAX) fault_total++;
      end

      if (use_count[victim] > peak_use) peak_use = use_count[victim];
      outcome.hit         = found;
      outcome.slot_index  = victim[lfu_pkg::SLOT_INDEX_W-1:0];
      outcome.fault_count = fault_total[lfu_pkg::FAULT_W-1:0];
      outcome_q.push_back(outcome);

      // end of run clears after the response is formed
      if (last) begin
         clear_table();
         clears++;
      end
   endfunction

   function void complain(string what, logic [15:0] want, logic [15:0] got);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch on %s at response %0d: expected %0h, got %0h",
                  what, checked, want, got);
   endfunction

   // compare one response transfer with the oldest prediction
   function void check_result(lfu_outcome_type seen);
      lfu_outcome_type want;
      checked++;
      if (outcome_q.size() == 0) begin
         complain("response with nothing outstanding", '0, seen.slot_index);
         return;
      end
      want = outcome_q.pop_front();
      if (seen.hit !== want.hit) complain("hit", want.hit, seen.hit);
      if (seen.slot_index !== want.slot_index)
         complain("slot_index", want.slot_index, seen.slot_index);
      if (seen.fault_count !== want.fault_count)
         complain("fault_count", want.fault_count, seen.fault_count);
   endfunction
endclass

module testbench;

   localparam int RANDOM_ITEMS   = 1800;
   localparam int HOT_REPEATS    = 40;
   localparam int SETTLE_CYCLES  = 2 * TABLE_SLOTS + 8;
   localparam int LONG_HOLD      = 300;
   localparam int WATCHDOG_LIMIT = 2000;

   logic                             clock = 1'b0;
   logic                             reset;
   logic                             req_valid;
   logic                             req_stall;
   logic [15:0]                      req_page;
   logic                             req_end_of_run;
   logic                             rsp_valid;
   logic                             rsp_stall;
   logic                             rsp_hit;
   logic [lfu_pkg::SLOT_INDEX_W-1:0] rsp_slot_index;
   logic [lfu_pkg::FAULT_W-1:0]      rsp_fault_count;
   logic                             csr_valid;
   logic                             csr_ready;
   logic [lfu_pkg::CFG_W-1:0]        csr_slots_in_use;

   lfu_scoreboard   board = new();
   lfu_outcome_type observed;
   int unsigned     req_gap_max = 5;
   int unsigned     rsp_gap_max = 5;
   bit              hold_request = 1'b0;
   int unsigned     holds_done = 0;
   int unsigned     settings_written = 0;
   int unsigned     quiet_cycles = 0;
   bit              moved;
   logic [15:0]     page_pool [24];

   lfu_page_replacement DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_page         (req_page),
      .req_end_of_run   (req_end_of_run),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_hit          (rsp_hit),
      .rsp_slot_index   (rsp_slot_index),
      .rsp_fault_count  (rsp_fault_count),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_slots_in_use (csr_slots_in_use)
   );

   always #1 clock = ~clock;

   // transfer monitor and watchdog
   always @(posedge clock) begin
      moved = 1'b0;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            board.note_reference(req_page, req_end_of_run);
            moved = 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            observed.hit         = rsp_hit;
            observed.slot_index  = rsp_slot_index;
            observed.fault_count = rsp_fault_count;
            board.check_result(observed);
            moved = 1'b1;
         end
         if (csr_valid && csr_ready) begin
            board.set_slot_count(csr_slots_in_use);
            moved = 1'b1;
         end
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
         $display("FAIL lfu_page_replacement");
         $finish;
      end
   end

   // response side: random stall before each transfer, one long hold on request
   initial begin : response_side
      int unsigned stall_len;
      rsp_stall = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            stall_len    = LONG_HOLD;
            hold_request = 1'b0;
            holds_done++;
         end else begin
            stall_len = $urandom_range(0, rsp_gap_max);
         end
         if (stall_len != 0) begin
            rsp_stall <= 1'b1;
            repeat (stall_len) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   // offer one reference after a random gap, return at its transfer
   task automatic send_reference(input logic [15:0] page, input logic last);
      int unsigned gap;
      gap = $urandom_range(0, req_gap_max);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_page       <= page;
      req_end_of_run <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // stop offering and let every outstanding response come back
   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_slot_count(input logic [lfu_pkg::CFG_W-1:0] value);
      csr_valid        <= 1'b1;
      csr_slots_in_use <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      settings_written++;
   endtask

   initial begin : stimulus
      logic [lfu_pkg::CFG_W-1:0] setting;
      logic [15:0]               page;
      int unsigned               random_sent;
      int unsigned               phase;
      int unsigned               len;
      int unsigned               n;
      int unsigned               upper;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_page         = '0;
      req_end_of_run   = 1'b0;
      csr_valid        = 1'b0;
      csr_slots_in_use = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // full table: extreme pages, a hit, alternating bit patterns
      req_gap_max = 2;
      send_reference(16'h0000, 1'b0);
      send_reference(16'hFFFF, 1'b0);
      send_reference(16'h0000, 1'b0);
      send_reference(16'h5555, 1'b0);
      send_reference(16'hAAAA, 1'b0);
      send_reference(16'h0001, 1'b0);
      wait_for_results();

      // two active slots: pages in slots beyond the range must not match,
      // and equal use counts fall to the oldest insertion
      write_slot_count(5'd2);
      send_reference(16'hAAAA, 1'b0);
      send_reference(16'hAAAA, 1'b0);
      send_reference(16'h1234, 1'b0);
      send_reference(16'h0000, 1'b0);
      send_reference(16'h1234, 1'b0);
      wait_for_results();

      // a slot count of zero behaves as one
      write_slot_count(5'd0);
      send_reference(16'h0042, 1'b0);
      send_reference(16'h0042, 1'b0);
      send_reference(16'h0043, 1'b0);
      wait_for_results();

      // an oversized count behaves as the full table; old slots come back
      write_slot_count(5'd31);
      send_reference(16'h5555, 1'b0);
      send_reference(16'h0001, 1'b0);
      send_reference(16'h7777, 1'b1);
      send_reference(16'h7777, 1'b0);
      send_reference(16'h5555, 1'b0);
      wait_for_results();

      // random phases over a range of slot counts
      random_sent = 0;
      phase       = 0;
      while (random_sent < RANDOM_ITEMS) begin
         wait_for_results();
         case (phase)
            0:       setting = 5'd16;
            1:       setting = 5'd1;
            2:       setting = 5'd0;
            3:       setting = 5'd31;
            4:       setting = 5'd17;
            5:       setting = 5'd2;
            6:       setting = 5'd15;
            default: setting = 5'($urandom_range(0, 31));
         endcase
         write_slot_count(setting);
         n = (setting == 0) ? 1 : (setting > TABLE_SLOTS) ? TABLE_SLOTS : setting;
         upper = (n + 2 > 23) ? 23 : n + 2;
         if (phase % 3 == 0) foreach (page_pool[i]) page_pool[i] = 16'($urandom);
         req_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 5;
         rsp_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 5;
         len = $urandom_range(60, 200);
         if (len > RANDOM_ITEMS - random_sent) len = RANDOM_ITEMS - random_sent;
         for (int k = 0; k < len; k++) begin
            // receiver holds off while references keep coming
            if (phase == 1 && k == 20) hold_request = 1'b1;
            // sender pauses until the block has answered everything
            if (phase == 2 && k == len / 2) wait_for_results();
            if ($urandom_range(0, 99) < 85) page = page_pool[$urandom_range(0, upper)];
            else page = 16'($urandom);
            send_reference(page, $urandom_range(0, 49) == 0);
            random_sent++;
         end
         phase++;
      end

      // hit one slot over and over, back to back
      wait_for_results();
      write_slot_count(5'd1);
      req_gap_max = 0;
      rsp_gap_max = 0;
      send_reference(16'h0BAD, 1'b1);
      for (int k = 0; k < HOT_REPEATS; k++) send_reference(16'hC0DE, 1'b0);
      wait_for_results();

      // the heavily used slot should stay resident while others churn
      write_slot_count(5'd3);
      req_gap_max = 5;
      rsp_gap_max = 5;
      for (int k = 0; k < 40; k++) begin
         page = (k % 7 == 0) ? 16'hC0DE : {12'h0A0, 4'($urandom_range(0, 4))};
         send_reference(page, k == 39);
      end
      wait_for_results();

      $display("covered %0d references: %0d hits, %0d faults, %0d table clears",
               board.references, board.hits, board.references - board.hits, board.clears);
      $display("%0d slot count writes incl. 0, 1, 16 and 31, peak use count %0d, %0d long holds",
               settings_written, board.peak_use, holds_done);
      if (board.mismatches == 0) begin
         $display("PASS lfu_page_replacement");
      end else begin
         $display("%0d mismatches in total", board.mismatches);
         $display("FAIL lfu_page_replacement");
      end
      $finish;
   end

endmodule

/* sim.f */
design/lfu_pkg.sv
design/lfu_ram.sv
design/lfu_datapath.sv
design/lfu_ctrl.sv
design/lfu_page_replacement.sv
dv/testbench.sv
